FILE: hdl/sme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sme_pkg;
    localparam int DIM_MAX   = 8;
    localparam int ELEM_BITS = 16;
    localparam int OUT_BITS  = 36;
    localparam int IDX_BITS  = $clog2(DIM_MAX);
    localparam int ADDR_BITS = 2 * IDX_BITS;
    localparam int DEPTH     = DIM_MAX * DIM_MAX;
    localparam int DIM_BITS  = 4;
    localparam int DIM_TOP   = (DIM_MAX < 8) ? DIM_MAX : 8;
    localparam int PROD_BITS = 2 * ELEM_BITS;
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = 2;

    typedef enum logic [2:0] {
        OP_LOAD_A = 3'd0,
        OP_LOAD_B = 3'd1,
        OP_ADD    = 3'd2,
        OP_SCALE  = 3'd3,
        OP_MUL    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CFG_A_ROWS = 2'd0,
        CFG_A_COLS = 2'd1,
        CFG_B_ROWS = 2'd2,
        CFG_B_COLS = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        K_ADD   = 2'd0,
        K_SCALE = 2'd1,
        K_MUL   = 2'd2,
        K_ERR   = 2'd3
    } kind_t;

    // one classified command for the back end
    typedef struct packed {
        kind_t                        kind;
        logic signed [ELEM_BITS-1:0]  scalar;
        logic [2:0]                   err_row;
        logic [2:0]                   err_col;
        logic [DIM_BITS-1:0]          rows;
        logic [DIM_BITS-1:0]          cols;
        logic [DIM_BITS-1:0]          inner;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS-1:0] r;
        begin
            if (v == '0)
                r = DIM_BITS'(1);
            else if (v > DIM_BITS'(DIM_TOP))
                r = DIM_BITS'(DIM_TOP);
            else
                r = v;
            return r;
        end
    endfunction
endpackage
`default_nettype wire

FILE: hdl/sme_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/sme_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sme_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sme_pkg::cmd_t push_data,
    input  wire logic          pop,
    output sme_pkg::cmd_t      head,
    output logic               not_empty,
    output logic               not_full
);
    import sme_pkg::*;

    cmd_t                 slot_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_reg, rd_reg;
    logic [QPTR_BITS:0]   cnt_reg;

    assign head      = slot_reg[rd_reg];
    assign not_empty = (cnt_reg != '0);
    assign not_full  = (cnt_reg != (QPTR_BITS+1)'(QDEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/sme_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sme_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         take,
    input  wire logic [2:0]                   opcode,
    input  wire logic signed [15:0]           value,
    input  wire logic [2:0]                   row,
    input  wire logic [2:0]                   col,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_sel,
    input  wire logic                         cfg_hit,
    input  wire logic [sme_pkg::DIM_BITS-1:0] cfg_val,
    output logic                              a_we,
    output logic                              b_we,
    output logic [sme_pkg::ADDR_BITS-1:0]     waddr,
    output logic [sme_pkg::ELEM_BITS-1:0]     wdata,
    output logic                              push,
    output sme_pkg::cmd_t                     cmd
);
    import sme_pkg::*;

    logic [DIM_BITS-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [DIM_BITS-1:0] nr, nc;
    logic                is_load, bad_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= clamp_dim(DIM_BITS'(8));
            a_cols_reg <= clamp_dim(DIM_BITS'(8));
            b_rows_reg <= clamp_dim(DIM_BITS'(8));
            b_cols_reg <= clamp_dim(DIM_BITS'(8));
        end
        else if (cfg_we && cfg_hit)
        begin
            unique case (cfg_idx_t'(cfg_sel))
                CFG_A_ROWS: a_rows_reg <= clamp_dim(cfg_val);
                CFG_A_COLS: a_cols_reg <= clamp_dim(cfg_val);
                CFG_B_ROWS: b_rows_reg <= clamp_dim(cfg_val);
                CFG_B_COLS: b_cols_reg <= clamp_dim(cfg_val);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        is_load = (opcode == OP_LOAD_A) || (opcode == OP_LOAD_B);
        nr      = (opcode == OP_LOAD_A) ? a_rows_reg : b_rows_reg;
        nc      = (opcode == OP_LOAD_A) ? a_cols_reg : b_cols_reg;
        bad_idx = ({1'b0, row} >= nr) || ({1'b0, col} >= nc);
        waddr   = {row[IDX_BITS-1:0], col[IDX_BITS-1:0]};
        wdata   = value[ELEM_BITS-1:0];
        a_we    = take && (opcode == OP_LOAD_A) && !bad_idx;
        b_we    = take && (opcode == OP_LOAD_B) && !bad_idx;
        cmd.scalar  = value[ELEM_BITS-1:0];
        cmd.err_row = 3'd0;
        cmd.err_col = 3'd0;
        cmd.rows    = a_rows_reg;
        cmd.cols    = a_cols_reg;
        cmd.inner   = a_cols_reg;
        cmd.kind    = K_ERR;
        push        = 1'b0;
        if (take)
        begin
            if (is_load)
            begin
                push        = bad_idx;
                cmd.err_row = row;
                cmd.err_col = col;
            end
            else if (opcode == OP_ADD)
            begin
                push = 1'b1;
                if (a_rows_reg == b_rows_reg && a_cols_reg == b_cols_reg)
                    cmd.kind = K_ADD;
            end
            else if (opcode == OP_SCALE)
            begin
                push     = 1'b1;
                cmd.kind = K_SCALE;
            end
            else if (opcode == OP_MUL)
            begin
                push     = 1'b1;
                cmd.cols = b_cols_reg;
                if (a_cols_reg == b_rows_reg)
                    cmd.kind = K_MUL;
            end
        end
    end
endmodule
`default_nettype wire

FILE: hdl/sme_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sme_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire sme_pkg::cmd_t                   head,
    input  wire logic                            not_empty,
    output logic                                 pop,
    output logic                                 busy_back,
    output logic [sme_pkg::ADDR_BITS-1:0]        a_raddr,
    output logic [sme_pkg::ADDR_BITS-1:0]        b_raddr,
    input  wire logic [sme_pkg::ELEM_BITS-1:0]   a_rdata,
    input  wire logic [sme_pkg::ELEM_BITS-1:0]   b_rdata,
    output logic                                 done,
    output logic signed [sme_pkg::OUT_BITS-1:0]  element,
    output logic [2:0]                           out_row,
    output logic [2:0]                           out_col,
    output logic                                 last,
    output logic                                 error
);
    import sme_pkg::*;

    localparam int ACC_BITS = PROD_BITS + IDX_BITS + 1;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [DIM_BITS-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    // pipeline: issue (read) -> s1 (data) -> s2 (product) -> accumulate/emit
    logic                v1_reg, v2_reg;
    logic                end1_reg, end2_reg, fin1_reg, fin2_reg;
    logic [2:0]          r1_reg, c1_reg, r2_reg, c2_reg;
    logic                issue, elem_end, all_end;
    logic signed [ELEM_BITS-1:0] a_s, b_s, opb;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [ELEM_BITS:0]   sum_reg;
    logic signed [ACC_BITS-1:0]  acc_reg, acc_sum;
    logic                done_reg, last_reg, err_reg;
    logic signed [OUT_BITS-1:0] elem_reg;
    logic [2:0]          orow_reg, ocol_reg;

    assign a_s = a_rdata;
    assign b_s = b_rdata;
    assign a_raddr = cmd_reg.kind == K_MUL ? {i_reg[IDX_BITS-1:0], k_reg[IDX_BITS-1:0]}
                                           : {i_reg[IDX_BITS-1:0], j_reg[IDX_BITS-1:0]};
    assign b_raddr = cmd_reg.kind == K_MUL ? {k_reg[IDX_BITS-1:0], j_reg[IDX_BITS-1:0]}
                                           : {i_reg[IDX_BITS-1:0], j_reg[IDX_BITS-1:0]};
    assign busy_back = (state_reg != ST_IDLE) || not_empty;
    assign done    = done_reg;
    assign element = elem_reg;
    assign out_row = orow_reg;
    assign out_col = ocol_reg;
    assign last    = last_reg;
    assign error   = err_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        pop        = 1'b0;
        issue      = 1'b0;
        elem_end   = 1'b1;
        all_end    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (not_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    i_next   = '0;
                    j_next   = '0;
                    k_next   = '0;
                    state_next = (head.kind == K_ERR) ? ST_IDLE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                issue = 1'b1;
                if (cmd_reg.kind == K_MUL)
                    elem_end = (k_reg + 1'b1 == cmd_reg.inner);
                all_end = elem_end && (j_reg + 1'b1 == cmd_reg.cols)
                          && (i_reg + 1'b1 == cmd_reg.rows);
                if (!elem_end)
                    k_next = k_reg + 1'b1;
                else
                begin
                    k_next = '0;
                    if (j_reg + 1'b1 == cmd_reg.cols)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                        j_next = j_reg + 1'b1;
                end
                if (all_end)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            done_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            done_reg  <= (pop && head.kind == K_ERR) || (v2_reg && end2_reg);
        end
    end

    assign opb     = (cmd_reg.kind == K_SCALE) ? cmd_reg.scalar : b_s;
    assign acc_sum = acc_reg + ACC_BITS'(prod_reg);

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        end1_reg <= elem_end;
        fin1_reg <= all_end;
        r1_reg   <= i_reg[2:0];
        c1_reg   <= j_reg[2:0];
        end2_reg <= end1_reg;
        fin2_reg <= fin1_reg;
        r2_reg   <= r1_reg;
        c2_reg   <= c1_reg;
        prod_reg <= a_s * opb;
        sum_reg  <= {a_s[ELEM_BITS-1], a_s} + {b_s[ELEM_BITS-1], b_s};
        if (v2_reg)
            acc_reg <= end2_reg ? '0 : acc_sum;
        if (pop && head.kind == K_ERR)
        begin
            elem_reg <= '0;
            orow_reg <= head.err_row;
            ocol_reg <= head.err_col;
            last_reg <= 1'b1;
            err_reg  <= 1'b1;
        end
        else
        begin
            elem_reg <= (cmd_reg.kind == K_ADD) ? OUT_BITS'(sum_reg) : OUT_BITS'(acc_sum);
            orow_reg <= r2_reg;
            ocol_reg <= c2_reg;
            last_reg <= fin2_reg;
            err_reg  <= 1'b0;
        end
        if (state_reg == ST_IDLE)
            acc_reg <= '0;
    end
endmodule
`default_nettype wire

FILE: hdl/small_matrix_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// small_matrix_engine: holds matrices A and B (up to 8x8, signed Q8.8) and
// runs add, scale and matrix product commands on them.
// input: an item is taken when start is high and busy is low. loads write
// one element per cycle while not busy, emitting only for an out-of-range index.
// results: each element is shown for one cycle with done high, in row-major
// order, last marks the final one; error items carry error and last.
// the receiver cannot stall, results are never held back.
// execution: add and scale emit one element per cycle; a product element is
// summed over a_cols terms by the single multiply-accumulate unit.
// a four-entry command queue sits between decode and execution; busy rises
// while the queue is full, and for a load while any command is still queued
// or executing, so a load never changes an element an earlier command reads.
// config writes (cfg_we, cfg_addr, cfg_data) must go in while idle, which the
// block itself does not enforce; zero becomes one and values above 8 become 8.
// reset: all sizes go to 8, queue and execution return to idle; matrix
// contents are undefined until loaded.
module small_matrix_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         opcode,
    input  wire logic signed [15:0] value,
    input  wire logic [2:0]         row,
    input  wire logic [2:0]         col,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_addr,
    input  wire logic [3:0]         cfg_data,
    output logic                    done,
    output logic signed [35:0]      element,
    output logic [2:0]              out_row,
    output logic [2:0]              out_col,
    output logic                    last,
    output logic                    error
);
    import sme_pkg::*;

    logic                 take, a_we, b_we, push, pop, q_ne, q_nf, busy_back;
    logic [ADDR_BITS-1:0] waddr, a_raddr, b_raddr;
    logic [ELEM_BITS-1:0] wdata, a_rdata, b_rdata;
    cmd_t                 cmd, head;

    // a load waits until the back end has finished every earlier command
    assign busy = !q_nf ||
                  (busy_back && ((opcode == OP_LOAD_A) || (opcode == OP_LOAD_B)));
    assign take = start && !busy;

    sme_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .opcode(opcode), .value(value),
        .row(row), .col(col), .cfg_we(cfg_we), .cfg_sel(cfg_addr),
        .cfg_hit(1'b1), .cfg_val(cfg_data), .a_we(a_we), .b_we(b_we),
        .waddr(waddr), .wdata(wdata), .push(push), .cmd(cmd)
    );

    sme_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(cmd), .pop(pop),
        .head(head), .not_empty(q_ne), .not_full(q_nf)
    );

    sme_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_ram_a (
        .clk(clk), .we(a_we), .waddr(waddr), .wdata(wdata),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    sme_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_ram_b (
        .clk(clk), .we(b_we), .waddr(waddr), .wdata(wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    sme_back u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .not_empty(q_ne), .pop(pop),
        .busy_back(busy_back), .a_raddr(a_raddr), .b_raddr(b_raddr),
        .a_rdata(a_rdata), .b_rdata(b_rdata), .done(done), .element(element),
        .out_row(out_row), .out_col(out_col), .last(last), .error(error)
    );
endmodule
`default_nettype wire
